// File: rtl/burh_pkg.sv
// Shared types, sizes and codes for the bounded undo/redo history block.
// No dependencies; imported by every module in rtl/.
package burh_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

	localparam logic [2:0] ACT_SEED    = 3'd0;
	localparam logic [2:0] ACT_PUSH    = 3'd1;
	localparam logic [2:0] ACT_UNDO    = 3'd2;
	localparam logic [2:0] ACT_REDO    = 3'd3;
	localparam logic [2:0] ACT_RESTORE = 3'd4;
	localparam logic [2:0] ACT_READ_AT = 3'd5;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_INVAL  = 2'd1;
	localparam logic [1:0] STS_NFOUND = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] entry_key;
		logic [31:0] doc_handle;
		logic [63:0] capture_time;
		logic        checkpoint_flag;
		logic [3:0]  read_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] doc_out;
		logic [31:0] key_out;
		logic [63:0] time_out;
		logic        checkpoint_out;
		logic [4:0]  entry_count;
		logic [3:0]  cursor_index;
		logic        cursor_valid;
		logic        can_undo;
		logic        can_redo;
		logic [4:0]  checkpoints_held;
		logic [31:0] revision;
	} rsp_t;

	// one stored history entry
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] doc;
		logic [63:0] stamp;
		logic        mark;
	} entry_t;

	// ring slot of a position counted from the oldest entry
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
		if (sum >= (CNT_W+1)'(HIST_DEPTH)) begin
			sum = sum - (CNT_W+1)'(HIST_DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

// File: rtl/burh_store.sv
// Entry memory of the history ring: one write port, one read port, registered read.
// Depends on burh_pkg.
module burh_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [burh_pkg::IDX_W-1:0]  wr_addr,
	input  burh_pkg::entry_t            wr_data,
	input  logic                        rd_en,
	input  logic [burh_pkg::IDX_W-1:0]  rd_addr,
	output burh_pkg::entry_t            rd_data
);
	import burh_pkg::*;

	entry_t mem [HIST_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/bounded_undo_redo_history_core.sv
// Top level of the bounded undo/redo history: control sequencer around the entry memory.
// Depends on burh_pkg and burh_store.
//
//  channel | valid     | stall     | payload | moves
//  --------+-----------+-----------+---------+----------------------------
//  command | cmd_valid | cmd_stall | cmd     | one action into the block
//  result  | rsp_valid | rsp_stall | rsp     | one result per action
//
// One command at a time. Seed and every refused action but an unmatched restore pass
// from the execute state straight to the emit state; undo, redo and read-at that succeed
// first read their entry from memory. Push then recounts the marks held, one per cycle.
// Restore reads one key from the entry memory per cycle until a match or the last entry.
// Reset clears the control state only; the entry memory is not cleared.
// A stalled result sits in the output register while the next command is worked on.
module bounded_undo_redo_history_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  burh_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output burh_pkg::rsp_t rsp
);
	import burh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SEARCH,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t            state_q;
	cmd_t              op_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [CNT_W-1:0]  held_q;
	logic [IDX_W-1:0]  cur_q;
	logic              present_q;
	logic [CNT_W-1:0]  tally_q;
	logic [31:0]       rev_q;
	logic [CNT_W-1:0]  pos_q;
	logic              chk_q;
	logic [IDX_W-1:0]  chk_pos_q;
	logic [1:0]        status_q;
	entry_t            entry_q;
	logic [HIST_DEPTH-1:0] mark_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_data;

	logic [CNT_W-1:0]  cur_ext;
	logic [CNT_W-1:0]  trim_cnt;
	logic [CNT_W-1:0]  base_cnt;
	logic [IDX_W-1:0]  base_ptr;
	logic [IDX_W-1:0]  push_slot;
	logic              undo_ok;
	logic              redo_ok;
	logic              key_zero;
	logic              issue;
	logic              hit;
	logic              rsp_free;

	burh_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cur_ext  = CNT_W'(cur_q);
	assign undo_ok  = (held_q > CNT_W'(1)) && present_q && (cur_q != '0);
	assign redo_ok  = present_q && ((cur_ext + CNT_W'(1)) < held_q);
	assign key_zero = (op_q.entry_key == '0);
	assign issue    = (pos_q < held_q);
	assign hit      = chk_q && (rd_data.key == op_q.entry_key);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// push: drop redo entries, then evict the oldest when full
	always_comb begin
		trim_cnt = held_q;
		if ((held_q != '0) && redo_ok) begin
			trim_cnt = cur_ext + CNT_W'(1);
		end
		base_ptr = oldest_q;
		base_cnt = trim_cnt;
		if (trim_cnt >= CNT_W'(HIST_DEPTH)) begin
			base_ptr = slot_of(oldest_q, CNT_W'(1));
			base_cnt = trim_cnt - CNT_W'(1);
		end
		push_slot = slot_of(base_ptr, base_cnt);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = push_slot;
		wr_data = '{key: op_q.entry_key, doc: op_q.doc_handle,
			stamp: op_q.capture_time, mark: op_q.checkpoint_flag};
		if (state_q == ST_EXEC && !key_zero) begin
			if (op_q.action == ACT_SEED) begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data.stamp = '0;
				wr_data.mark  = 1'b1;
			end else if (op_q.action == ACT_PUSH) begin
				wr_en = 1'b1;
			end
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_of(oldest_q, pos_q);
		case (state_q)
			ST_EXEC: begin
				rd_en = 1'b1;
				case (op_q.action)
					ACT_UNDO:    rd_addr = slot_of(oldest_q, cur_ext - CNT_W'(1));
					ACT_REDO:    rd_addr = slot_of(oldest_q, cur_ext + CNT_W'(1));
					ACT_READ_AT: rd_addr = slot_of(oldest_q, CNT_W'(op_q.read_index));
					default:     rd_en = 1'b0;
				endcase
			end
			ST_SEARCH: rd_en = issue;
			default:   rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			oldest_q    <= '0;
			held_q      <= '0;
			cur_q       <= '0;
			present_q   <= 1'b0;
			tally_q     <= '0;
			rev_q       <= 32'd1;
			pos_q       <= '0;
			chk_q       <= 1'b0;
			chk_pos_q   <= '0;
			status_q    <= STS_OK;
			entry_q     <= '0;
			mark_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the emit state sets the flag itself when the register drains
			if (rsp_valid_q && !rsp_stall && (state_q != ST_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					pos_q    <= '0;
					chk_q    <= 1'b0;
					status_q <= STS_OK;
					entry_q  <= wr_data;
					state_q  <= ST_EMIT;
					case (op_q.action)
						ACT_SEED: begin
							oldest_q  <= '0;
							held_q    <= '0;
							cur_q     <= '0;
							present_q <= 1'b0;
							tally_q   <= '0;
							rev_q     <= 32'd1;
							if (key_zero) begin
								status_q <= STS_INVAL;
							end else begin
								mark_q[0] <= 1'b1;
								held_q    <= CNT_W'(1);
								present_q <= 1'b1;
								tally_q   <= CNT_W'(1);
								rev_q     <= 32'd2;
							end
						end
						ACT_PUSH: begin
							if (key_zero) begin
								status_q <= STS_INVAL;
							end else begin
								mark_q[push_slot] <= op_q.checkpoint_flag;
								oldest_q  <= base_ptr;
								held_q    <= base_cnt + CNT_W'(1);
								cur_q     <= IDX_W'(base_cnt);
								present_q <= 1'b1;
								rev_q     <= rev_q + 32'd1;
								tally_q   <= '0;
								state_q   <= ST_COUNT;
							end
						end
						ACT_UNDO: begin
							if (undo_ok) begin
								cur_q   <= cur_q - IDX_W'(1);
								rev_q   <= rev_q + 32'd1;
								state_q <= ST_READ;
							end else begin
								status_q <= STS_NFOUND;
							end
						end
						ACT_REDO: begin
							if (redo_ok) begin
								cur_q   <= cur_q + IDX_W'(1);
								rev_q   <= rev_q + 32'd1;
								state_q <= ST_READ;
							end else begin
								status_q <= STS_NFOUND;
							end
						end
						ACT_RESTORE: begin
							if (key_zero) begin
								status_q <= STS_INVAL;
							end else begin
								state_q <= ST_SEARCH;
							end
						end
						ACT_READ_AT: begin
							if (CNT_W'(op_q.read_index) < held_q) begin
								state_q <= ST_READ;
							end else begin
								status_q <= STS_NFOUND;
							end
						end
						default: status_q <= STS_INVAL;
					endcase
				end
				ST_READ: begin
					entry_q <= rd_data;
					state_q <= ST_EMIT;
				end
				ST_SEARCH: begin
					// key read issued one cycle, compared the next
					if (hit) begin
						cur_q     <= chk_pos_q;
						present_q <= 1'b1;
						rev_q     <= rev_q + 32'd1;
						entry_q   <= rd_data;
						state_q   <= ST_EMIT;
					end else if (!issue) begin
						status_q <= STS_NFOUND;
						state_q  <= ST_EMIT;
					end else begin
						pos_q     <= pos_q + CNT_W'(1);
						chk_q     <= 1'b1;
						chk_pos_q <= IDX_W'(pos_q);
					end
				end
				ST_COUNT: begin
					if (issue) begin
						tally_q <= tally_q + CNT_W'(mark_q[slot_of(oldest_q, pos_q)]);
						pos_q   <= pos_q + CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rsp_free) begin
						rsp_q.status           <= status_q;
						rsp_q.doc_out          <= (status_q == STS_OK) ? entry_q.doc : '0;
						rsp_q.key_out          <= (status_q == STS_OK) ? entry_q.key : '0;
						rsp_q.time_out         <= (status_q == STS_OK) ? entry_q.stamp : '0;
						rsp_q.checkpoint_out   <= (status_q == STS_OK) && entry_q.mark;
						rsp_q.entry_count      <= 5'(held_q);
						rsp_q.cursor_index     <= present_q ? 4'(cur_q) : 4'd0;
						rsp_q.cursor_valid     <= present_q;
						rsp_q.can_undo         <= undo_ok;
						rsp_q.can_redo         <= redo_ok;
						rsp_q.checkpoints_held <= 5'(tally_q);
						rsp_q.revision         <= rev_q;
						rsp_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/burh_checker.sv
// Port-level checks for bounded_undo_redo_history_core, attached by bind.
// Depends on burh_pkg.
module burh_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input burh_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input burh_pkg::rsp_t rsp
);
	import burh_pkg::*;

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// failed actions carry no entry
	a_fail_blank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STS_OK) |->
		(rsp.doc_out == '0) && (rsp.key_out == '0) && (rsp.time_out == '0) &&
		!rsp.checkpoint_out)
		else $error("entry fields set on failed transaction");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= 5'(HIST_DEPTH)) &&
		(rsp.checkpoints_held <= rsp.entry_count))
		else $error("count or checkpoint tally out of range");

	a_no_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.cursor_valid |->
		(rsp.cursor_index == '0) && !rsp.can_undo && !rsp.can_redo)
		else $error("cursor flags set without a cursor");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.cursor_valid |-> 5'(rsp.cursor_index) < rsp.entry_count)
		else $error("cursor beyond held entries");

endmodule

bind bounded_undo_redo_history_core burh_checker u_burh_checker (.*);

// File: dv/bounded_undo_redo_history_core_tb.sv
// Self-checking testbench for bounded_undo_redo_history_core: directed then random actions,
// each result checked field by field against an in-bench model of the history ring.
// Depends on burh_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module bounded_undo_redo_history_core_tb;
	import burh_pkg::*;

	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS  = 1025;
	localparam int PHASE1_AT     = 350;
	localparam int PHASE2_AT     = 700;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int KEY_POOL      = 24;

	typedef struct {
		cmd_t c;
		bit   drain_first;
	} job_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// history model state
	entry_t      hist_mem [HIST_DEPTH];
	int unsigned h_base, h_count, h_cur;
	bit          h_cur_ok;
	logic [31:0] h_rev;

	job_t  pending_q[$];
	rsp_t  results_due[$];
	int    n_accepted, n_checked, n_errors, n_evicted, cycles;
	int    act_seen [8];
	int    status_seen [4];
	int    hold_left;
	bit    hold_done;

	bounded_undo_redo_history_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one action to the model history and returns the result it should give.
	function automatic rsp_t apply_action(input cmd_t c);
		rsp_t        r;
		bit          hit;
		int unsigned pos, i, s, marks;
		r = '0;
		hit = 1'b0;
		pos = 0;
		r.status = STS_OK;
		case (c.action)
			ACT_SEED: begin
				h_base = 0;
				h_count = 0;
				h_cur = 0;
				h_cur_ok = 1'b0;
				h_rev = 32'd1;
				if (c.entry_key == 32'd0) begin
					r.status = STS_INVAL;
				end else begin
					hist_mem[0] = '{key: c.entry_key, doc: c.doc_handle, stamp: 64'd0, mark: 1'b1};
					h_count = 1;
					h_cur_ok = 1'b1;
					h_rev++;
					hit = 1'b1;
				end
			end
			ACT_PUSH: begin
				if (c.entry_key == 32'd0) begin
					r.status = STS_INVAL;
				end else begin
					// redo entries above the cursor are dropped
					if (h_count > 0 && h_cur_ok && h_cur + 1 < h_count)
						h_count = h_cur + 1;
					if (h_count >= HIST_DEPTH) begin
						h_base = (h_base + 1) % HIST_DEPTH;
						h_count--;
						if (h_cur > 0)
							h_cur--;
						n_evicted++;
					end
					s = (h_base + h_count) % HIST_DEPTH;
					hist_mem[s] = '{key: c.entry_key, doc: c.doc_handle,
						stamp: c.capture_time, mark: c.checkpoint_flag};
					h_count++;
					h_cur = h_count - 1;
					h_cur_ok = 1'b1;
					h_rev++;
					hit = 1'b1;
					pos = h_cur;
				end
			end
			ACT_UNDO: begin
				if (!(h_count > 1 && h_cur_ok && h_cur > 0)) begin
					r.status = STS_NFOUND;
				end else begin
					h_cur--;
					h_rev++;
					hit = 1'b1;
					pos = h_cur;
				end
			end
			ACT_REDO: begin
				if (!(h_cur_ok && h_cur + 1 < h_count)) begin
					r.status = STS_NFOUND;
				end else begin
					h_cur++;
					h_rev++;
					hit = 1'b1;
					pos = h_cur;
				end
			end
			ACT_RESTORE: begin
				if (c.entry_key == 32'd0) begin
					r.status = STS_INVAL;
				end else begin
					r.status = STS_NFOUND;
					// oldest match wins
					for (i = 0; i < h_count && !hit; i++) begin
						if (hist_mem[(h_base + i) % HIST_DEPTH].key == c.entry_key) begin
							h_cur = i;
							h_cur_ok = 1'b1;
							h_rev++;
							r.status = STS_OK;
							hit = 1'b1;
							pos = i;
						end
					end
				end
			end
			ACT_READ_AT: begin
				if (c.read_index >= h_count) begin
					r.status = STS_NFOUND;
				end else begin
					hit = 1'b1;
					pos = 32'(c.read_index);
				end
			end
			default: r.status = STS_INVAL;
		endcase

		marks = 0;
		for (i = 0; i < h_count; i++)
			marks += 32'(hist_mem[(h_base + i) % HIST_DEPTH].mark);

		if (hit) begin
			s = (h_base + pos) % HIST_DEPTH;
			r.doc_out        = hist_mem[s].doc;
			r.key_out        = hist_mem[s].key;
			r.time_out       = hist_mem[s].stamp;
			r.checkpoint_out = hist_mem[s].mark;
		end
		r.entry_count      = CNT_W'(h_count);
		r.cursor_index     = h_cur_ok ? IDX_W'(h_cur) : '0;
		r.cursor_valid     = h_cur_ok;
		r.can_undo         = h_count > 1 && h_cur_ok && h_cur > 0;
		r.can_redo         = h_cur_ok && h_cur + 1 < h_count;
		r.checkpoints_held = CNT_W'(marks);
		r.revision         = h_rev;
		return r;
	endfunction

	function automatic int idle_pct(input bit sender);
		if (n_accepted < PHASE1_AT)
			return sender ? 6 : 63;
		if (n_accepted < PHASE2_AT)
			return sender ? 63 : 6;
		return 0;
	endfunction

	task automatic queue_cmd(input logic [2:0] act, input logic [31:0] key,
			input logic [31:0] doc, input logic [63:0] stamp, input logic flag,
			input logic [3:0] idx, input bit drain);
		job_t j;
		j.c = '{action: act, entry_key: key, doc_handle: doc, capture_time: stamp,
			checkpoint_flag: flag, read_index: idx};
		j.drain_first = drain;
		pending_q.push_back(j);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (n_errors < 100)
			$display("[%0t] result %0d: %s got %0h, want %0h", $time, n_checked, what, got, want);
		n_errors++;
	endtask

	// command driver: model is updated as each transaction is accepted
	always @(posedge clk or negedge arst_n) begin : drive
		int pct;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				results_due.push_back(apply_action(cmd));
				act_seen[cmd.action]++;
				n_accepted++;
			end
			if (!cmd_valid || !cmd_stall) begin
				pct = idle_pct(1'b1);
				if (pending_q.size() != 0
						&& !(pending_q[0].drain_first && results_due.size() != 0)
						&& $urandom_range(0, 99) >= pct) begin
					cmd <= pending_q[0].c;
					cmd_valid <= 1'b1;
					void'(pending_q.pop_front());
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result stall: random, plus one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= $urandom_range(0, 99) < idle_pct(1'b0);
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(rsp.status), 64'd0);
			end else begin
				want = results_due.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.doc_out !== want.doc_out)
					report_mismatch("doc_out", 64'(rsp.doc_out), 64'(want.doc_out));
				if (rsp.key_out !== want.key_out)
					report_mismatch("key_out", 64'(rsp.key_out), 64'(want.key_out));
				if (rsp.time_out !== want.time_out)
					report_mismatch("time_out", rsp.time_out, want.time_out);
				if (rsp.checkpoint_out !== want.checkpoint_out)
					report_mismatch("checkpoint_out", 64'(rsp.checkpoint_out),
						64'(want.checkpoint_out));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
				if (rsp.cursor_index !== want.cursor_index)
					report_mismatch("cursor_index", 64'(rsp.cursor_index),
						64'(want.cursor_index));
				if (rsp.cursor_valid !== want.cursor_valid)
					report_mismatch("cursor_valid", 64'(rsp.cursor_valid),
						64'(want.cursor_valid));
				if (rsp.can_undo !== want.can_undo)
					report_mismatch("can_undo", 64'(rsp.can_undo), 64'(want.can_undo));
				if (rsp.can_redo !== want.can_redo)
					report_mismatch("can_redo", 64'(rsp.can_redo), 64'(want.can_redo));
				if (rsp.checkpoints_held !== want.checkpoints_held)
					report_mismatch("checkpoints_held", 64'(rsp.checkpoints_held),
						64'(want.checkpoints_held));
				if (rsp.revision !== want.revision)
					report_mismatch("revision", 64'(rsp.revision), 64'(want.revision));
				status_seen[want.status]++;
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				results_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] key_pool [KEY_POOL];
		logic [31:0] key;
		logic [2:0]  act;
		int          roll;

		h_base = 0;
		h_count = 0;
		h_cur = 0;
		h_cur_ok = 1'b0;
		h_rev = 32'd1;
		n_accepted = 0;
		n_checked = 0;
		n_errors = 0;
		n_evicted = 0;
		cycles = 0;

		// before any seed: refusals, then a push onto the empty history
		queue_cmd(ACT_SPARE_HI, 32'd7, 32'd7, 64'd7, 1'b1, 4'd7, 1'b0);
		queue_cmd(ACT_UNDO, 32'd1, 32'd1, 64'd1, 1'b0, 4'd0, 1'b0);
		queue_cmd(ACT_READ_AT, 32'd1, 32'd0, 64'd0, 1'b0, 4'd15, 1'b0);
		queue_cmd(ACT_RESTORE, 32'd0, 32'd0, 64'd0, 1'b0, 4'd0, 1'b0);
		queue_cmd(ACT_PUSH, 32'd0, 32'hFFFF_FFFF, '1, 1'b1, 4'd0, 1'b0);
		queue_cmd(ACT_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 1'b1, 4'd15, 1'b0);
		// zero-key seed still wipes the history
		queue_cmd(ACT_SEED, 32'd0, 32'h1234_5678, '1, 1'b0, 4'd0, 1'b0);
		queue_cmd(ACT_SEED, 32'd1, 32'd0, '1, 1'b0, 4'd0, 1'b0);
		// fill past the depth so the seed entry is evicted; duplicate key tests oldest match
		for (int i = 0; i < 16; i++) begin
			key = (i == 3 || i == 9) ? 32'hA5A5_A5A5 : (32'h8000_0000 | i);
			queue_cmd(ACT_PUSH, key, ~i, {32'(i), ~32'(i)}, i[0], 4'(i), 1'b0);
		end
		queue_cmd(ACT_RESTORE, 32'hA5A5_A5A5, 32'd0, 64'd0, 1'b0, 4'd0, 1'b0);

		for (int i = 0; i < KEY_POOL; i++) begin
			key_pool[i] = $urandom;
			if (key_pool[i] == 32'd0)
				key_pool[i] = 32'd1;
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				act = ACT_SEED;
			else if (roll < 45)
				act = ACT_PUSH;
			else if (roll < 60)
				act = ACT_UNDO;
			else if (roll < 72)
				act = ACT_REDO;
			else if (roll < 85)
				act = ACT_RESTORE;
			else if (roll < 97)
				act = ACT_READ_AT;
			else
				act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
			if ($urandom_range(0, 15) == 0)
				key = 32'd0;
			else if ($urandom_range(0, 3) != 0)
				key = key_pool[$urandom_range(0, KEY_POOL - 1)];
			else
				key = $urandom;
			queue_cmd(act, key, $urandom, {$urandom, $urandom}, 1'($urandom),
				4'($urandom_range(0, 15)), n == 480 || n == 900);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || cmd_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch("results never returned", 64'(results_due.size()), 64'd0);

		$display("%0d transactions: seed %0d push %0d undo %0d redo %0d restore %0d read %0d spare %0d",
			n_accepted, act_seen[ACT_SEED], act_seen[ACT_PUSH], act_seen[ACT_UNDO],
			act_seen[ACT_REDO], act_seen[ACT_RESTORE], act_seen[ACT_READ_AT],
			act_seen[ACT_SPARE_LO] + act_seen[ACT_SPARE_HI]);
		$display("%0d results checked: ok %0d invalid %0d not found %0d, %0d evictions",
			n_checked, status_seen[STS_OK], status_seen[STS_INVAL], status_seen[STS_NFOUND],
			n_evicted);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
